### src/mgl_pkg.sv
// Shared types, constants and helper functions of the mesh edge gradient limiter.
package mgl_pkg;

  localparam int MAX_TRIANGLES = 1024;
  localparam int COMPONENTS    = 4;
  localparam int SLOT_LIMIT    = MAX_TRIANGLES * COMPONENTS;

  localparam int SLOT_W  = 12;
  localparam int VAL_W   = 32;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W;
  localparam int NUM_W   = ACC_W + 16;
  localparam int DEN_W   = ACC_W;
  localparam int QUOT_W  = 32;
  localparam int LIM_W   = 17;
  localparam int COMP_W  = 2;
  localparam int FLOOR_W = 31;

  localparam logic [LIM_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [2:0] CFG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_FLOOR_0 = 3'd1;
  localparam logic [2:0] CFG_FLOOR_1 = 3'd2;
  localparam logic [2:0] CFG_FLOOR_2 = 3'd3;
  localparam logic [2:0] CFG_FLOOR_3 = 3'd4;

  localparam logic OP_TRIANGLE = 1'b0;
  localparam logic OP_EDGE     = 1'b1;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
  } mem_wr_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  // Magnitude of a signed accumulator value.
  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  function automatic logic slot_in_range(input logic [SLOT_W-1:0] s);
    slot_in_range = (32'(s) < 32'(SLOT_LIMIT));
  endfunction

endpackage

### src/mesh_edge_gradient_limiter.sv
// Top level of the mesh edge gradient limiter: sequencer, shared multiplier and datapath.
// Sequence: a triangle transaction keeps busy high through 8 multiply steps and, unless
// degenerate, two divisions; an edge transaction reads, multiplies, divides (unless the
// denominator is zero) and cubes, or answers in the cycle after acceptance when disabled.
// Throughput: one transaction at a time; the 32-step divider sets the rate.
// Reset: rst_n is synchronous and active low; it clears the sequencer and configuration,
// while the gradient memories hold undefined data until written. The receiver cannot stall.
module mesh_edge_gradient_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [11:0]                 in_slot_a,
  input  logic [11:0]                 in_slot_b,
  input  logic signed [31:0]          in_px1,
  input  logic signed [31:0]          in_py1,
  input  logic signed [31:0]          in_px2,
  input  logic signed [31:0]          in_py2,
  input  logic signed [31:0]          in_px3,
  input  logic signed [31:0]          in_py3,
  input  logic signed [31:0]          in_val1,
  input  logic signed [31:0]          in_val2,
  input  logic signed [31:0]          in_val3,
  output logic                        out_valid,
  output logic [16:0]                 out_limit_factor,
  output logic [1:0]                  out_component,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [30:0]                 cfg_wdata
);
  import mgl_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_TMUL  = 8'b0000_0010,
    S_TDIV  = 8'b0000_0100,
    S_EREAD = 8'b0000_1000,
    S_EMUL  = 8'b0001_0000,
    S_EPREP = 8'b0010_0000,
    S_EDIV  = 8'b0100_0000,
    S_ECUBE = 8'b1000_0000
  } state_t;

  state_t state_r;
  logic [2:0] step_r;

  // Configuration registers.
  logic               enable_r;
  logic [FLOOR_W-1:0] floor_r [COMPONENTS];

  // Captured transaction. For an edge, e1 holds the edge vector.
  logic [SLOT_W-1:0]        slot_a_r;
  logic [SLOT_W-1:0]        slot_b_r;
  logic [COMP_W-1:0]        comp_r;
  logic signed [DIFF_W-1:0] e1x_r, e1y_r, e2x_r, e2y_r, d1_r, d2_r;

  // Shared multiplier and accumulators.
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r [3];

  // Gradients read for an edge.
  logic signed [VAL_W-1:0] glx_r, gly_r, grx_r, gry_r;
  logic                    oor_r;

  // Division operands and results.
  logic [ACC_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [ACC_W-1:0]  den_sum_r;
  logic              neg_r;
  logic              div_sel_r;
  logic [VAL_W-1:0]  gx_r;
  logic [LIM_W-1:0]  a_r;
  logic              div_start;
  div_res_t          div_res;

  logic [VAL_W-1:0]  g_nxt;
  logic [VAL_W-1:0]  g_lim;
  logic [VAL_W-1:0]  g_mag;
  logic [LIM_W-1:0]  a_nxt;
  logic [DEN_W-1:0]  fl;
  logic [DEN_W-1:0]  den_nxt;

  // Memory interface.
  mem_wr_t           wr;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rd_x, rd_y;

  // Result register.
  logic              out_valid_r;
  logic [LIM_W-1:0]  out_limit_factor_r;
  logic [COMP_W-1:0] out_component_r;

  logic accept;
  logic det_zero;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign det_zero = (acc_r[0] == '0);

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TMUL: begin
        unique case (step_r)
          3'd0: begin mul_a = MUL_W'(e1x_r); mul_b = MUL_W'(e2y_r); end
          3'd1: begin mul_a = MUL_W'(e2x_r); mul_b = MUL_W'(e1y_r); end
          3'd2: begin mul_a = MUL_W'(d1_r);  mul_b = MUL_W'(e2y_r); end
          3'd3: begin mul_a = MUL_W'(d2_r);  mul_b = MUL_W'(e1y_r); end
          3'd4: begin mul_a = MUL_W'(e1x_r); mul_b = MUL_W'(d2_r);  end
          3'd5: begin mul_a = MUL_W'(e2x_r); mul_b = MUL_W'(d1_r);  end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_EMUL: begin
        unique case (step_r)
          3'd0: begin mul_a = MUL_W'(e1x_r); mul_b = MUL_W'(glx_r); end
          3'd1: begin mul_a = MUL_W'(e1y_r); mul_b = MUL_W'(gly_r); end
          3'd2: begin mul_a = MUL_W'(e1x_r); mul_b = MUL_W'(grx_r); end
          3'd3: begin mul_a = MUL_W'(e1y_r); mul_b = MUL_W'(gry_r); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_ECUBE: begin
        // The square is at most 2^32, so it fits the signed operand.
        mul_a = $signed({(MUL_W - LIM_W)'(0), a_r});
        mul_b = (step_r == 3'd0) ? $signed({(MUL_W - LIM_W)'(0), a_r})
                                 : $signed(prod_r[MUL_W-1:0]);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Saturated, signed gradient from the divider result.
  always_comb begin
    g_lim = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    g_mag = (div_res.ovf || div_res.quot > g_lim) ? g_lim : div_res.quot;
    g_nxt = neg_r ? VAL_W'(-g_mag) : g_mag;
  end

  // The ratio is capped at one.
  assign a_nxt = (div_res.ovf || div_res.quot > QUOT_W'(ONE_Q16)) ? ONE_Q16
                                                                  : div_res.quot[LIM_W-1:0];

  assign fl      = DEN_W'({floor_r[comp_r], 16'h0000});
  assign den_nxt = (den_sum_r >= fl) ? den_sum_r : fl;

  assign div_start = ((state_r == S_TDIV) || (state_r == S_EDIV)) && (step_r == 3'd0);

  // Gradient write: zero for a degenerate triangle after the multiply steps, else after the second division.
  always_comb begin
    wr.addr = slot_a_r;
    wr.en   = 1'b0;
    wr.x    = gx_r;
    wr.y    = g_nxt;
    if (state_r == S_TMUL && step_r == 3'd7 && det_zero) begin
      wr.en = slot_in_range(slot_a_r);
      wr.x  = '0;
      wr.y  = '0;
    end else if (state_r == S_TDIV && step_r != 3'd0 && div_res.done && div_sel_r) begin
      wr.en = slot_in_range(slot_a_r);
    end
  end

  assign rd_en   = (state_r == S_EREAD) && (step_r != 3'd2);
  assign rd_addr = (step_r == 3'd0) ? slot_a_r : slot_b_r;

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int k = 0; k < COMPONENTS; k++) begin
        floor_r[k] <= FLOOR_W'(ONE_Q16);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:  enable_r   <= cfg_wdata[0];
        CFG_FLOOR_0: floor_r[0] <= cfg_wdata;
        CFG_FLOOR_1: floor_r[1] <= cfg_wdata;
        CFG_FLOOR_2: floor_r[2] <= cfg_wdata;
        CFG_FLOOR_3: floor_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            slot_a_r <= in_slot_a;
            slot_b_r <= in_slot_b;
            comp_r   <= COMP_W'(in_slot_a % COMPONENTS);
            e1x_r    <= DIFF_W'(in_px2) - DIFF_W'(in_px1);
            e1y_r    <= DIFF_W'(in_py2) - DIFF_W'(in_py1);
            e2x_r    <= DIFF_W'(in_px3) - DIFF_W'(in_px1);
            e2y_r    <= DIFF_W'(in_py3) - DIFF_W'(in_py1);
            d1_r     <= DIFF_W'(in_val2) - DIFF_W'(in_val1);
            d2_r     <= DIFF_W'(in_val3) - DIFF_W'(in_val1);
            step_r   <= '0;
            if (in_opcode == OP_TRIANGLE) begin
              state_r <= S_TMUL;
            end else if (enable_r) begin
              state_r <= S_EREAD;
            end else begin
              // Disabled limiter: the result goes out at once.
              out_valid_r        <= 1'b1;
              out_limit_factor_r <= ONE_Q16;
              out_component_r    <= COMP_W'(in_slot_a % COMPONENTS);
            end
          end
        end
        S_TMUL: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd1: acc_r[0] <= prod_r;
            3'd2: acc_r[0] <= acc_r[0] - prod_r;
            3'd3: acc_r[1] <= prod_r;
            3'd4: acc_r[1] <= acc_r[1] - prod_r;
            3'd5: acc_r[2] <= prod_r;
            3'd6: acc_r[2] <= acc_r[2] - prod_r;
            3'd7: begin
              num_r     <= mag(acc_r[1]);
              den_r     <= mag(acc_r[0]);
              neg_r     <= acc_r[1][ACC_W-1] ^ acc_r[0][ACC_W-1];
              div_sel_r <= 1'b0;
              step_r    <= '0;
              state_r   <= det_zero ? S_IDLE : S_TDIV;
            end
            default: ;
          endcase
        end
        S_TDIV: begin
          if (step_r == 3'd0) begin
            step_r <= 3'd1;
          end else if (div_res.done) begin
            step_r <= '0;
            if (!div_sel_r) begin
              gx_r      <= g_nxt;
              num_r     <= mag(acc_r[2]);
              neg_r     <= acc_r[2][ACC_W-1] ^ acc_r[0][ACC_W-1];
              div_sel_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_EREAD: begin
          step_r <= step_r + 3'd1;
          oor_r  <= !slot_in_range(rd_addr);
          if (step_r == 3'd1) begin
            glx_r <= oor_r ? '0 : rd_x;
            gly_r <= oor_r ? '0 : rd_y;
          end else if (step_r == 3'd2) begin
            grx_r   <= oor_r ? '0 : rd_x;
            gry_r   <= oor_r ? '0 : rd_y;
            step_r  <= '0;
            state_r <= S_EMUL;
          end
        end
        S_EMUL: begin
          step_r <= step_r + 3'd1;
          unique case (step_r)
            3'd1: acc_r[0] <= prod_r;
            3'd2: acc_r[0] <= acc_r[0] + prod_r;
            3'd3: acc_r[1] <= prod_r;
            3'd4: begin
              acc_r[1] <= acc_r[1] + prod_r;
              step_r   <= '0;
              state_r  <= S_EPREP;
            end
            default: ;
          endcase
        end
        S_EPREP: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd0) begin
            acc_r[2] <= acc_r[1] - acc_r[0];
            acc_r[0] <= $signed(mag(acc_r[0]));
            acc_r[1] <= $signed(mag(acc_r[1]));
          end else if (step_r == 3'd1) begin
            num_r     <= mag(acc_r[2]);
            den_sum_r <= $unsigned(acc_r[0]) + $unsigned(acc_r[1]);
          end else begin
            den_r  <= den_nxt;
            step_r <= '0;
            // A zero denominator gives a ratio of zero without a division.
            if (den_nxt == '0) begin
              a_r     <= '0;
              state_r <= S_ECUBE;
            end else begin
              state_r <= S_EDIV;
            end
          end
        end
        S_EDIV: begin
          if (step_r == 3'd0) begin
            step_r <= 3'd1;
          end else if (div_res.done) begin
            a_r     <= a_nxt;
            step_r  <= '0;
            state_r <= S_ECUBE;
          end
        end
        S_ECUBE: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd2) begin
            out_valid_r        <= 1'b1;
            out_limit_factor_r <= ONE_Q16 - prod_r[48:32];
            out_component_r    <= comp_r;
            step_r             <= '0;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mgl_grad_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  mgl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({num_r, 16'h0000}),
    .den   (den_r),
    .res   (div_res)
  );

  assign out_valid        = out_valid_r;
  assign out_limit_factor = out_limit_factor_r;
  assign out_component    = out_component_r;

  // An accepted transaction either starts work or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid)
    else $error("accepted transaction neither started nor answered");

  // The limit never exceeds one.
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_limit_factor <= ONE_Q16)
    else $error("limit factor above one");

  // Gradient writes happen only while a triangle is in progress.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_TMUL || state_r == S_TDIV))
    else $error("gradient write outside a triangle transaction");

  // The divider is never started while a result is being delivered.
  a_div_out: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !out_valid)
    else $error("divider started while a result is on the outputs");

endmodule

### src/mgl_grad_mem.sv
// Gradient memories: x and y components, one write port and one registered read port.
module mgl_grad_mem (
  input  logic                       clk,
  input  mgl_pkg::mem_wr_t           wr,
  input  logic                       rd_en,
  input  logic [mgl_pkg::SLOT_W-1:0] rd_addr,
  output logic [mgl_pkg::VAL_W-1:0]  rd_x,
  output logic [mgl_pkg::VAL_W-1:0]  rd_y
);
  import mgl_pkg::*;

  logic [VAL_W-1:0] mem_x [2**SLOT_W];
  logic [VAL_W-1:0] mem_y [2**SLOT_W];
  logic [VAL_W-1:0] rd_x_r;
  logic [VAL_W-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_x[wr.addr] <= wr.x;
      mem_y[wr.addr] <= wr.y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;
endmodule

### src/mgl_div.sv
// Iterative restoring divider giving a 32-bit quotient and an overflow flag.
module mgl_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mgl_pkg::NUM_W-1:0] num,
  input  logic [mgl_pkg::DEN_W-1:0] den,
  output mgl_pkg::div_res_t         res
);
  import mgl_pkg::*;

  logic              run_r;
  logic [4:0]        cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [QUOT_W-1:0] nlo_r;
  logic [QUOT_W-1:0] q_r;
  logic [DEN_W-1:0]  den_r;
  logic              done_r;
  logic              ovf_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic              ovf_nxt;

  assign trial   = {rem_r, nlo_r[QUOT_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  // A quotient that does not fit in 32 bits is flagged up front.
  assign ovf_nxt = ({(DEN_W + QUOT_W - NUM_W)'(0), num} >= {den, QUOT_W'(0)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        ovf_r <= ovf_nxt;
        q_r   <= '0;
        rem_r <= DEN_W'(num[NUM_W-1:QUOT_W]);
        nlo_r <= num[QUOT_W-1:0];
        cnt_r <= '0;
        if (ovf_nxt) begin
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        q_r   <= {q_r[QUOT_W-2:0], ge};
        nlo_r <= {nlo_r[QUOT_W-2:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = q_r;
endmodule
